// ===== design/utf8v_pkg.sv =====
// utf8v_pkg: shared types and byte-class constants for the utf-8 stream validator
// no dependencies; used by utf8v_step and utf8_stream_validator_top

package utf8v_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CntW  = 3;

  // byte-class masks and patterns
  localparam logic [ByteW-1:0] MaskHi1   = 8'h80;
  localparam logic [ByteW-1:0] MaskHi2   = 8'hC0;
  localparam logic [ByteW-1:0] MaskHi3   = 8'hE0;
  localparam logic [ByteW-1:0] MaskHi4   = 8'hF0;
  localparam logic [ByteW-1:0] MaskHi5   = 8'hF8;
  localparam logic [ByteW-1:0] MaskHi6   = 8'hFC;
  localparam logic [ByteW-1:0] MaskHi7   = 8'hFE;
  localparam logic [ByteW-1:0] PatCont   = 8'h80;
  localparam logic [ByteW-1:0] PatLead2  = 8'hC0;
  localparam logic [ByteW-1:0] PatLead3  = 8'hE0;
  localparam logic [ByteW-1:0] PatLead4  = 8'hF0;
  localparam logic [ByteW-1:0] PatLead5  = 8'hF8;
  localparam logic [ByteW-1:0] PatLead6  = 8'hFC;
  localparam logic [ByteW-1:0] PatSurr   = 8'hA0;
  localparam logic [ByteW-1:0] LeadSurr  = 8'hED;
  localparam logic [ByteW-1:0] LeadNonch = 8'hEF;
  localparam logic [ByteW-1:0] ByteBf    = 8'hBF;
  localparam logic [ByteW-1:0] ByteBe    = 8'hBE;

  localparam logic [CntW-1:0] MaxRemain  = 3'd5;

  typedef struct packed {
    logic [CntW-1:0]  remain;   // continuation bytes still expected
    logic [ByteW-1:0] lead;     // lead byte of the open sequence
    logic [CntW-1:0]  pos;      // index of the next continuation byte
    logic             fffe;     // sequence began ef bf
    logic             err;      // invalid form found
    logic             ended;    // zero byte seen
  } scan_state_t;

endpackage

// ===== design/utf8v_step.sv =====
// utf8v_step: next-state and verdict logic for one byte of the string
// depends on utf8v_pkg

module utf8v_step (
  input  utf8v_pkg::scan_state_t       cur,
  input  logic [utf8v_pkg::ByteW-1:0]  byte_in,
  input  logic                         last_in,
  output utf8v_pkg::scan_state_t       nxt,
  output logic                         ok
);

  logic [utf8v_pkg::CntW-1:0] need;
  logic                       lead_bad;
  logic                       cont_bad;
  logic                       set_fffe;
  utf8v_pkg::scan_state_t     upd;

  // lead byte classification
  always_comb begin
    need     = '0;
    lead_bad = 1'b0;
    if ((byte_in & utf8v_pkg::MaskHi1) == '0) begin
      need = '0;
    end else if ((byte_in & utf8v_pkg::MaskHi3) == utf8v_pkg::PatLead2) begin
      if ((byte_in & utf8v_pkg::MaskHi7) == utf8v_pkg::PatLead2) begin
        lead_bad = 1'b1;
      end else begin
        need = 3'd1;
      end
    end else if ((byte_in & utf8v_pkg::MaskHi4) == utf8v_pkg::PatLead3) begin
      need = 3'd2;
    end else if ((byte_in & utf8v_pkg::MaskHi5) == utf8v_pkg::PatLead4) begin
      need = 3'd3;
    end else if ((byte_in & utf8v_pkg::MaskHi6) == utf8v_pkg::PatLead5) begin
      need = 3'd4;
    end else if ((byte_in & utf8v_pkg::MaskHi7) == utf8v_pkg::PatLead6) begin
      need = 3'd5;
    end else begin
      lead_bad = 1'b1;
    end
  end

  // continuation byte checks: overlong, surrogate and fffe/ffff forms
  always_comb begin
    cont_bad = 1'b0;
    set_fffe = 1'b0;
    if ((byte_in & utf8v_pkg::MaskHi2) != utf8v_pkg::PatCont) begin
      cont_bad = 1'b1;
    end else if (cur.pos == 3'd1) begin
      if ((cur.lead == utf8v_pkg::PatLead3 &&
           (byte_in & utf8v_pkg::MaskHi3) == utf8v_pkg::PatCont) ||
          (cur.lead == utf8v_pkg::LeadSurr &&
           (byte_in & utf8v_pkg::MaskHi3) == utf8v_pkg::PatSurr) ||
          (cur.lead == utf8v_pkg::PatLead4 &&
           (byte_in & utf8v_pkg::MaskHi4) == utf8v_pkg::PatCont) ||
          (cur.lead == utf8v_pkg::PatLead5 &&
           (byte_in & utf8v_pkg::MaskHi5) == utf8v_pkg::PatCont) ||
          (cur.lead == utf8v_pkg::PatLead6 &&
           (byte_in & utf8v_pkg::MaskHi6) == utf8v_pkg::PatCont)) begin
        cont_bad = 1'b1;
      end else if (cur.lead == utf8v_pkg::LeadNonch && byte_in == utf8v_pkg::ByteBf) begin
        set_fffe = 1'b1;
      end
    end else if (cur.pos == 3'd2) begin
      if (cur.lead == utf8v_pkg::LeadNonch && cur.fffe &&
          (byte_in & utf8v_pkg::MaskHi7) == utf8v_pkg::ByteBe) begin
        cont_bad = 1'b1;
      end
    end
  end

  always_comb begin
    upd = cur;
    if (!cur.ended && !cur.err) begin
      if (byte_in == '0) begin
        if (cur.remain != '0) begin
          upd.err = 1'b1;
        end
        upd.ended = 1'b1;
      end else if (cur.remain == '0) begin
        if (lead_bad) begin
          upd.err = 1'b1;
        end else if (need != '0) begin
          upd.remain = need;
          upd.lead   = byte_in;
          upd.pos    = 3'd1;
          upd.fffe   = 1'b0;
        end
      end else if (cont_bad) begin
        upd.err = 1'b1;
      end else begin
        upd.remain = cur.remain - 3'd1;
        upd.pos    = cur.pos + 3'd1;
        if (set_fffe) begin
          upd.fffe = 1'b1;
        end
      end
    end else if (byte_in == '0) begin
      upd.ended = 1'b1;
    end
  end

  assign ok  = !upd.err && (upd.remain == '0);
  // a verdict closes the string and starts the next from scratch
  assign nxt = last_in ? '0 : upd;

endmodule

// ===== design/utf8_stream_validator_top.sv =====
// utf8_stream_validator_top: byte-stream utf-8 checker with input stage and result register
// depends on utf8v_pkg and utf8v_step

// Takes one byte per cycle on the in_ stream (in_tlast flags the final byte of the buffer)
// and returns one verdict per buffer on the out_ stream, in out_tdata[0], 1 for valid.
// Sustained rate is one byte per clock while no flagged byte waits; each verdict passes
// through the input stage, then the result register. Bytes that do not end a buffer
// keep flowing while an earlier verdict waits on out_tready; only a flagged byte waits for
// the result register to free. Accepts 1- to 6-byte sequences (leads up to fd), rejects
// overlong forms, c0/c1, surrogates, u+fffe/ffff and stray bytes; a zero byte ends the
// string and later bytes up to in_tlast are ignored.

module utf8_stream_validator_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] byte_value
  input  logic       in_tlast,   // last_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] is_valid, [7:1] zero
);

  logic                       stg_vld_r;
  logic [utf8v_pkg::ByteW-1:0] stg_byte_r;
  logic                       stg_last_r;
  logic                       stg_adv;
  utf8v_pkg::scan_state_t     st_r;
  utf8v_pkg::scan_state_t     st_nxt;
  logic                       ok;
  logic                       out_vld_r;
  logic                       out_ok_r;

  // a byte without the last flag produces nothing, so it never waits on the output
  assign stg_adv   = stg_vld_r && (!stg_last_r || !out_vld_r || out_tready);
  assign in_tready = !stg_vld_r || stg_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (in_tready) begin
      stg_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      stg_byte_r <= in_tdata;
      stg_last_r <= in_tlast;
    end
  end

  utf8v_step u_step (
    .cur     (st_r),
    .byte_in (stg_byte_r),
    .last_in (stg_last_r),
    .nxt     (st_nxt),
    .ok      (ok)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (stg_adv) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (stg_adv && stg_last_r) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_adv && stg_last_r) begin
      out_ok_r <= ok;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, out_ok_r};

  a_reset_after_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_adv && stg_last_r) |=> (st_r == '0))
    else $error("scan state not cleared after verdict");

  a_verdict_registered: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_adv && stg_last_r) |=> out_vld_r)
    else $error("verdict not presented after flagged byte");

  a_remain_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.remain <= utf8v_pkg::MaxRemain)
    else $error("expected continuation count out of range");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.err && !(stg_adv && stg_last_r)) |=> st_r.err)
    else $error("error flag dropped before end of string");

  a_pos_open_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.remain != '0) |-> (st_r.pos != '0))
    else $error("open sequence without position");

endmodule
